### hw/rtl/mbd_pkg.sv
// Shared types, constants and lane helpers for the 2x2 mipmap downsampler.
package mbd_pkg;

  localparam int PIX_W   = 32;
  localparam int LANE_W  = 9;
  localparam int SUM_W   = 4 * LANE_W;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int COL_W   = 12;
  localparam int XCOL_W  = COL_W - 1;

  typedef logic [PIX_W-1:0]     pix_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;

  // register indexes on the config port
  localparam cfg_idx_t CFG_TARGET_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_TARGET_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_SRC_ROW_PIX   = 2'd2;

  // line store command
  typedef struct packed {
    logic wr;
    logic rd;
  } ls_cmd_t;

  // four 8-bit channels into four 9-bit lanes
  function automatic sum_t spread(input pix_t p);
    return {1'b0, p[31:24], 1'b0, p[23:16], 1'b0, p[15:8], 1'b0, p[7:0]};
  endfunction

  // lane-wise add, no carry between lanes (lanes stay below 512)
  function automatic sum_t lane_add(input sum_t a, input sum_t b);
    sum_t r;
    for (int c = 0; c < 4; c++) begin
      r[c*LANE_W +: LANE_W] = a[c*LANE_W +: LANE_W] + b[c*LANE_W +: LANE_W];
    end
    return r;
  endfunction

  // sum of two pair sums, divided by four, per channel
  function automatic pix_t lane_avg(input sum_t a, input sum_t b);
    pix_t        r;
    logic [9:0]  s;
    for (int c = 0; c < 4; c++) begin
      s = {1'b0, a[c*LANE_W +: LANE_W]} + {1'b0, b[c*LANE_W +: LANE_W]};
      r[c*8 +: 8] = s[9:2];
    end
    return r;
  endfunction

endpackage

### hw/rtl/mbd_in_if.sv
// Source pixel channel: valid/ready plus one ARGB8888 pixel.
interface mbd_in_if;
  logic            valid;
  logic            ready;
  mbd_pkg::pix_t   src_pixel;

  modport source (output valid, output src_pixel, input ready);
  modport sink   (input valid, input src_pixel, output ready);
endinterface

### hw/rtl/mbd_out_if.sv
// Result pixel channel: valid/ready plus averaged pixel and row/frame markers.
interface mbd_out_if;
  logic            valid;
  logic            ready;
  mbd_pkg::pix_t   out_pixel;
  logic            row_end;
  logic            frame_end;

  modport source (output valid, output out_pixel, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input out_pixel, input row_end, input frame_end,
                  output ready);
endinterface

### hw/rtl/mbd_line_store.sv
// Line store: one-port synchronous RAM of per-column pair sums, registered read.
module mbd_line_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic               clk,
  input  mbd_pkg::ls_cmd_t   cmd,
  input  logic [AW-1:0]      addr,
  input  mbd_pkg::sum_t      wdata,
  output mbd_pkg::sum_t      rdata
);
  import mbd_pkg::*;

  sum_t mem [DEPTH];
  sum_t rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/mipmap_box_downsample_2x2.sv
// Top level of the 2x2 box-filter mipmap downsampler (ARGB8888).
//
// Takes source pixels in raster order, one transaction per clock, and emits
// one averaged pixel per 2x2 block: each channel is (a+b+c+d)>>2, truncated.
// Even source rows store per-column pair sums in a line store RAM
// (MAX_OUT_WIDTH x 36 bits, no reset, no clearing pass); odd source rows read
// the stored sum back and complete the block. Throughput is one source pixel
// per clock, sustained under no backpressure; the line store has one port and
// each source pixel uses it at most once. A completing block sits in s1
// while its RAM read is in flight, then its add is registered into the
// output register. Columns at or past 2*target_width are dropped; the row
// counter wraps after 2*target_height source rows. Registers are to be
// written through cfg_* only while the block is idle (the block itself does
// not enforce it): 0 = target_width, 1 = target_height, 2 = source_row_pixels.
module mipmap_box_downsample_2x2 #(
  parameter int MAX_OUT_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mbd_in_if.sink                in_s,
  mbd_out_if.source             out_m,
  input  logic                  cfg_we,
  input  mbd_pkg::cfg_idx_t     cfg_index,
  input  mbd_pkg::cfg_data_t    cfg_data
);
  import mbd_pkg::*;

  localparam int AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

  // ---------------------------------------------------------------- config
  logic [11:0] tw_r, th_r;
  logic [12:0] srp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r  <= 12'd1;
      th_r  <= 12'd1;
      srp_r <= 13'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_WIDTH:  tw_r  <= cfg_data[11:0];
        CFG_TARGET_HEIGHT: th_r  <= cfg_data[11:0];
        CFG_SRC_ROW_PIX:   srp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective limits: zero acts as one, clamp to maxima
  logic [13:0] w_raw, eff_w;
  logic [14:0] two_w;
  logic [11:0] h_raw;
  logic [12:0] h2;
  logic [12:0] len_raw, eff_len;

  always_comb begin
    w_raw   = (tw_r == 12'd0) ? 14'd1 : {2'b00, tw_r};
    eff_w   = (w_raw > 14'(MAX_OUT_WIDTH)) ? 14'(MAX_OUT_WIDTH) : w_raw;
    two_w   = {eff_w, 1'b0};
    h_raw   = (th_r == 12'd0) ? 12'd1 : th_r;   // 12 bits already caps at 4095
    h2      = (h_raw > 12'd2048) ? 13'd4096 : {h_raw, 1'b0};
    len_raw = (srp_r == 13'd0) ? 13'd1 : srp_r;
    eff_len = (len_raw > 13'd4096) ? 13'd4096 : len_raw;
  end

  // ---------------------------------------------------------------- pipeline
  // s1: RAM read in flight for a completing block; o: output register
  logic        s1_v_r, s1_row_end_r, s1_frame_end_r;
  sum_t        s1_pair_r;
  logic        o_v_r, o_row_end_r, o_frame_end_r;
  pix_t        o_pix_r;

  logic        o_free, s1_move, in_ready, in_acc;

  assign o_free   = !o_v_r || out_m.ready;
  assign s1_move  = s1_v_r && o_free;
  assign in_ready = !s1_v_r || o_free;
  assign in_acc   = in_s.valid && in_ready;

  // ---------------------------------------------------------------- stage 0
  logic [11:0]       col_r, row_r;
  logic [11:0]       col_nxt, row_nxt;
  sum_t              hold_r, hold_nxt;
  sum_t              pix_s, pair;
  logic              in_rng, odd_col, odd_row, emit, last_x, last_row;
  logic [XCOL_W-1:0] x;
  logic [XCOL_W+AW-1:0] x_wide;
  logic [12:0]       col_p1, row_p1;
  ls_cmd_t           ls_cmd;
  sum_t              ls_rdata;

  always_comb begin
    pix_s    = spread(in_s.src_pixel);
    pair     = lane_add(hold_r, pix_s);
    in_rng   = ({3'b000, col_r} < two_w) && ({1'b0, row_r} < h2);
    odd_col  = col_r[0];
    odd_row  = row_r[0];
    x        = col_r[COL_W-1:1];
    x_wide   = {{AW{1'b0}}, x};
    emit     = in_rng && odd_col && odd_row;
    last_x   = ({3'b000, x} == (eff_w - 14'd1));
    last_row = ({1'b0, row_r} == (h2 - 13'd1));

    ls_cmd.wr = in_acc && in_rng && odd_col && !odd_row;
    ls_cmd.rd = in_acc && emit;

    hold_nxt = (in_acc && in_rng && !odd_col) ? pix_s : hold_r;

    col_p1 = {1'b0, col_r} + 13'd1;
    row_p1 = {1'b0, row_r} + 13'd1;
    if (col_p1 >= eff_len) begin
      col_nxt = 12'd0;
      row_nxt = (row_p1 >= h2) ? 12'd0 : row_p1[11:0];
    end else begin
      col_nxt = col_p1[11:0];
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      hold_r <= '0;
    end else begin
      hold_r <= hold_nxt;
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // Write (even row) and read (odd row) of one column are a full source row
  // apart, so a read always sees the finished write: no forwarding needed.
  mbd_line_store #(
    .DEPTH (MAX_OUT_WIDTH),
    .AW    (AW)
  ) u_line_store (
    .clk   (clk),
    .cmd   (ls_cmd),
    .addr  (x_wide[AW-1:0]),
    .wdata (pair),
    .rdata (ls_rdata)
  );

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= emit;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      s1_pair_r      <= pair;
      s1_row_end_r   <= last_x;
      s1_frame_end_r <= last_x && last_row;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (s1_move) begin
      o_v_r <= 1'b1;
    end else if (out_m.ready) begin
      o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      o_pix_r       <= lane_avg(ls_rdata, s1_pair_r);
      o_row_end_r   <= s1_row_end_r;
      o_frame_end_r <= s1_frame_end_r;
    end
  end

  assign in_s.ready      = in_ready;
  assign out_m.valid     = o_v_r;
  assign out_m.out_pixel = o_pix_r;
  assign out_m.row_end   = o_row_end_r;
  assign out_m.frame_end = o_frame_end_r;

  // ---------------------------------------------------------------- checks
`ifndef ASSERT_OFF
  a_frame_has_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r |-> (!o_frame_end_r || o_row_end_r))
    else $error("frame_end without row_end");

  a_ls_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ls_cmd.wr && ls_cmd.rd))
    else $error("line store read and write in one cycle");

  a_emit_reaches_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit) |=> s1_v_r)
    else $error("completing block lost before stage 1");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && o_v_r))
    else $error("input stalled with free pipeline slot");
`endif

endmodule

### tb/mbd_downsample_checker.sv
// Checker for the 2x2 mipmap downsampler: predicts block averages and compares results.
module mbd_downsample_checker #(
  parameter int MAX_OUT_WIDTH = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  mbd_in_if                  src_mon,
  mbd_out_if                 res_mon,
  input  logic               cfg_we,
  input  mbd_pkg::cfg_idx_t  cfg_index,
  input  mbd_pkg::cfg_data_t cfg_data,
  output int                 pending_results,
  output int                 mismatch_count
);
  import mbd_pkg::*;

  typedef struct packed {
    pix_t pixel;
    logic row_end;
    logic frame_end;
  } block_avg_t;

  // shadow registers and geometry counters
  logic [11:0] width_reg;
  logic [11:0] height_reg;
  logic [12:0] row_len_reg;
  int          col_at;
  int          row_at;

  // lanes of the even-column pixel, and per-column pair sums of the even row
  sum_t        held_pair;
  sum_t        column_pair_sums [MAX_OUT_WIDTH];

  block_avg_t  block_avg_q [$];

  task automatic fold_source_pixel(input pix_t px);
    int         w;
    int         h2;
    int         len;
    int         x;
    sum_t       lanes;
    sum_t       pair;
    sum_t       above;
    logic [9:0] acc;
    block_avg_t avg;
    w   = (width_reg == 0) ? 1 :
          ((int'(width_reg) > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : int'(width_reg));
    h2  = 2 * ((height_reg == 0) ? 1 : ((int'(height_reg) > 2048) ? 2048 : int'(height_reg)));
    len = (row_len_reg == 0) ? 1 : ((int'(row_len_reg) > 4096) ? 4096 : int'(row_len_reg));
    for (int c = 0; c < 4; c++) begin
      lanes[9*c +: 9] = {1'b0, px[8*c +: 8]};
    end
    if (col_at < 2 * w && row_at < h2) begin
      if (col_at % 2 == 0) begin
        held_pair = lanes;
      end else begin
        x = col_at / 2;
        for (int c = 0; c < 4; c++) begin
          pair[9*c +: 9] = held_pair[9*c +: 9] + lanes[9*c +: 9];
        end
        if (row_at % 2 == 0) begin
          column_pair_sums[x] = pair;
        end else begin
          above = column_pair_sums[x];
          for (int c = 0; c < 4; c++) begin
            acc = {1'b0, above[9*c +: 9]} + {1'b0, pair[9*c +: 9]};
            avg.pixel[8*c +: 8] = acc[9:2];
          end
          avg.row_end   = (x == w - 1);
          avg.frame_end = (x == w - 1) && (row_at == h2 - 1);
          block_avg_q.push_back(avg);
        end
      end
    end
    // counters past a shrunken limit wrap on this step
    if (col_at + 1 >= len) begin
      col_at = 0;
      row_at = (row_at + 1 >= h2) ? 0 : row_at + 1;
    end else begin
      col_at = col_at + 1;
    end
  endtask

  always @(posedge clk) begin
    block_avg_t want;
    if (!rst_n) begin
      width_reg   = 12'd1;
      height_reg  = 12'd1;
      row_len_reg = 13'd2;
      held_pair   = '0;
      col_at      = 0;
      row_at      = 0;
      mismatch_count = 0;
      block_avg_q.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (block_avg_q.size() == 0) begin
          $error("out_pixel: expected nothing, got %08h", res_mon.out_pixel);
          mismatch_count++;
        end else begin
          want = block_avg_q.pop_front();
          if (res_mon.out_pixel !== want.pixel) begin
            $error("out_pixel: expected %08h, got %08h", want.pixel, res_mon.out_pixel);
            mismatch_count++;
          end
          if (res_mon.row_end !== want.row_end) begin
            $error("row_end: expected %0b, got %0b", want.row_end, res_mon.row_end);
            mismatch_count++;
          end
          if (res_mon.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, res_mon.frame_end);
            mismatch_count++;
          end
        end
      end
      if (src_mon.valid && src_mon.ready) begin
        fold_source_pixel(src_mon.src_pixel);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_WIDTH:  width_reg   = cfg_data[11:0];
          CFG_TARGET_HEIGHT: height_reg  = cfg_data[11:0];
          CFG_SRC_ROW_PIX:   row_len_reg = cfg_data;
          default: ;
        endcase
      end
    end
    pending_results = block_avg_q.size();
  end

endmodule

### tb/tb_mipmap_box_downsample_2x2.sv
// Testbench top for the 2x2 mipmap downsampler: stimulus, back-pressure and verdict.
module tb_mipmap_box_downsample_2x2;
  import mbd_pkg::*;

  localparam int OUT_W_MAX    = 2048;
  localparam int SETTLE_CYCLES = 8;     // margin that wait_drained adds after the last result
  localparam int LONG_HOLD    = 300;    // receiver hold-off during the pressure phase
  localparam int RANDOM_ITEMS = 520;

  // corner pixels, four frames at the reset geometry (one block per frame):
  // all zero, all ones, truncation of 255+255+255+254, and mixed lanes
  localparam pix_t CORNER_PIXELS [16] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFEFE_FEFE,
    32'h807F_0103, 32'h7F80_0200, 32'h0100_FF03, 32'h0003_FE01
  };

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;
  int        pending_results;
  int        mismatch_count;

  // both sides idle at random unless quiet is set
  bit        quiet;
  bit        long_hold_req;

  mbd_in_if  src_ch ();
  mbd_out_if res_ch ();

  mipmap_box_downsample_2x2 #(.MAX_OUT_WIDTH(OUT_W_MAX)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (src_ch),
    .out_m     (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mbd_downsample_checker #(.MAX_OUT_WIDTH(OUT_W_MAX)) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .src_mon         (src_ch),
    .res_mon         (res_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #12_000_000;
    $display("mipmap_box_downsample_2x2 verification failed");
    $finish;
  end

  // Mostly raw random pixels; some saturated words and per-lane 00/FF mixes so
  // the lane sums hit their top and bottom.
  function automatic pix_t pick_pixel();
    pix_t px;
    case ($urandom_range(7, 0))
      0: px = '0;
      1: px = '1;
      2: begin
        px = $urandom;
        for (int c = 0; c < 4; c++) begin
          px[8*c +: 8] = px[8*c] ? 8'hFF : 8'h00;
        end
      end
      default: px = $urandom;
    endcase
    return px;
  endfunction

  // One source transaction. Entered and left at a falling edge; valid stays
  // high when the next pixel follows with no gap.
  task automatic send_pixel(input pix_t px);
    int gap;
    gap = quiet ? 0 : $urandom_range(9, 0);
    if (gap > 0) begin
      src_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_ch.valid     <= 1'b1;
    src_ch.src_pixel <= px;
    do @(posedge clk); while (!src_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_pixels(input int count);
    repeat (count) send_pixel(pick_pixel());
    src_ch.valid <= 1'b0;
  endtask

  // Sender pause: every expected result in, then a SETTLE_CYCLES margin for
  // pixels that make no result but may still be in flight.
  task automatic wait_drained();
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all three registers on back-to-back cycles; the block is idle here.
  task automatic set_geometry(input cfg_data_t w, input cfg_data_t h, input cfg_data_t len);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TARGET_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= CFG_TARGET_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_index <= CFG_SRC_ROW_PIX;
    cfg_data  <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Result side: a random hold-off before each transaction, plus one long
  // hold-off when the stimulus asks for it.
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      stall = quiet ? 0 : $urandom_range(9, 0);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid && !long_hold_req);
    end
  end

  initial begin : stimulus
    int         w;
    int         h;
    int         len;
    int         eff_h;
    int         eff_len;
    int         frames;
    int         random_items;
    cfg_data_t  w_code;
    cfg_data_t  h_code;

    rst_n            = 1'b0;
    src_ch.valid     = 1'b0;
    src_ch.src_pixel = '0;
    res_ch.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_TARGET_WIDTH;
    cfg_data         = '0;
    quiet            = 1'b0;
    long_hold_req    = 1'b0;
    random_items     = 0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: corner pixels at the reset geometry (1x1 target, 2-pixel rows).
    foreach (CORNER_PIXELS[i]) send_pixel(CORNER_PIXELS[i]);
    src_ch.valid <= 1'b0;

    // Zero width and height act as one.
    wait_drained();
    set_geometry(13'd0, 13'd0, 13'd2);
    send_pixels(4);

    // Zero row length acts as one: every pixel sits in column 0, nothing out.
    wait_drained();
    set_geometry(13'd1, 13'd1, 13'd0);
    send_pixels(6);

    // Short source rows: 6 pixels against 16 expected, no row or frame markers.
    wait_drained();
    set_geometry(13'd8, 13'd2, 13'd6);
    send_pixels(24);

    // Counters past new bounds: one full 4x2 frame, then stop inside row 2 at
    // column 5 and shrink everything. The next pixel is dropped and both
    // counters wrap; the line store entry read afterwards was written above.
    wait_drained();
    set_geometry(13'd4, 13'd2, 13'd8);
    send_pixels(32 + 21);
    wait_drained();
    set_geometry(13'd1, 13'd1, 13'd3);
    send_pixels(1 + 2 * 6);

    // Pressure: receiver holds off for a long stretch while the sender streams
    // a whole frame back to back, so the block fills and stalls its input.
    wait_drained();
    set_geometry(13'd8, 13'd4, 13'd16);
    quiet         = 1'b1;
    long_hold_req = 1'b1;
    send_pixels(128);
    quiet = 1'b0;

    // Oversized width and row length: clamp to 2048 outputs and 4096 pixels.
    // Upper cfg_data bit is dropped for the 12-bit width register. Only the
    // start of row 0 goes in; it fills the low line store entries.
    wait_drained();
    set_geometry(13'h1FFF, 13'd1, 13'h1FFF);
    send_pixels(16);

    // Oversized height: 2048 output rows. The column counter sits past the new
    // row length, so the next pixel is dropped and row 1 starts, reading entry
    // 0 written above. No frame marker within the first eight rows.
    wait_drained();
    set_geometry(13'd0, 13'h0FFF, 13'd2);
    send_pixels(1 + 2 * 7);

    // Back to a 1x1 frame: row 8 is past the new height, so its two pixels are
    // dropped and both counters wrap before one full frame.
    wait_drained();
    set_geometry(13'd1, 13'd1, 13'd2);
    send_pixels(2 + 4);

    // Random phases: whole frames at random small geometries, so each phase
    // starts with both counters at zero and reads only rows written this frame.
    while (random_items < RANDOM_ITEMS) begin
      w     = $urandom_range(8, 0);
      h     = $urandom_range(3, 0);
      eff_h = (h == 0) ? 1 : h;
      case ($urandom_range(9, 0))
        0, 1:    len = $urandom_range(2 * ((w == 0) ? 1 : w) - 1, 1);  // short rows
        2:       len = 0;
        default: len = 2 * ((w == 0) ? 1 : w) + $urandom_range(3, 0);
      endcase
      eff_len = (len == 0) ? 1 : len;
      frames  = $urandom_range(3, 1);
      w_code  = cfg_data_t'(w) | (cfg_data_t'($urandom_range(1, 0)) << 12);
      h_code  = cfg_data_t'(h) | (cfg_data_t'($urandom_range(1, 0)) << 12);
      wait_drained();
      set_geometry(w_code, h_code, cfg_data_t'(len));
      quiet = ($urandom_range(3, 0) == 0);
      send_pixels(frames * 2 * eff_h * eff_len);
      random_items += frames * 2 * eff_h * eff_len;
    end
    quiet = 1'b0;

    // wind down: all results in, then a little margin for stray transactions
    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("mipmap_box_downsample_2x2 verification clean");
    end else begin
      $display("mipmap_box_downsample_2x2 verification failed");
    end
    $finish;
  end

endmodule
